FILE: rtl/core/i2c_master_bit_sequencer_defines.svh
// Assertion macros shared by the I2C bit sequencer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

// Next-cycle implication, disabled while reset is high.
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`endif

FILE: rtl/core/i2cms_pkg.sv
// Types and constants of the I2C master bit sequencer.
// No dependencies; used by i2cms_seq and the top level.
package i2cms_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RESTART,
    PH_START_A,
    PH_START_B,
    PH_WB_SETUP,
    PH_WB_HIGH,
    PH_WB_LOW,
    PH_RB_HIGH,
    PH_RB_LOW,
    PH_STOP_A,
    PH_STOP_B
  } phase_t;

  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_START_WRITE = 3'd1;
  localparam logic [2:0] KIND_WRITE_BYTE  = 3'd2;
  localparam logic [2:0] KIND_END_WRITE   = 3'd3;
  localparam logic [2:0] KIND_START_READ  = 3'd4;
  localparam logic [2:0] KIND_READ_BYTE   = 3'd5;

  // 10-bit address header: 11110 A9 A8 R/W
  localparam logic [4:0] HDR10_PREFIX = 5'b11110;
  localparam logic [9:0] ADDR7_LIMIT  = 10'h080;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] delay_count;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [7:0]  pending_low_byte;
    logic        pending_flag;
    logic [15:0] bytes_left;
    logic        bus_started;
    logic        ack_flag;
    logic [2:0]  active_command;
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
  } seq_state_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_enable;
    logic        busy_res;
    logic        accepted;
    logic        done_res;
    logic        acked;
    logic        read_valid;
    logic [7:0]  read_data;
    logic [15:0] remaining;
  } result_t;

endpackage

FILE: rtl/core/i2cms_seq.sv
// Phase sequencer of the I2C master: state register plus one-step next-state logic.
// Depends on i2cms_pkg.
module i2cms_seq #(
  parameter int COUNT_MAX = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [2:0]          kind,
  input  logic [9:0]          address,
  input  logic [7:0]          data,
  input  logic [15:0]         count,
  input  logic                sda_in,
  input  logic [15:0]         delay,
  output i2cms_pkg::result_t  result
);

  localparam logic [15:0] CountMax = 16'(COUNT_MAX);

  i2cms_pkg::seq_state_t state;
  i2cms_pkg::seq_state_t state_next;

  logic                  do_enter;
  i2cms_pkg::phase_t     target;
  logic                  accepted;
  logic                  done_now;
  logic                  read_now;
  logic                  wbit;
  logic [7:0]            header;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= i2cms_pkg::PH_IDLE;
      state.delay_count      <= '0;
      state.bit_index        <= '0;
      state.shift_byte       <= '0;
      state.pending_low_byte <= '0;
      state.pending_flag     <= 1'b0;
      state.bytes_left       <= '0;
      state.bus_started      <= 1'b0;
      state.ack_flag         <= 1'b1;
      state.active_command   <= i2cms_pkg::KIND_TICK;
      state.scl_level        <= 1'b1;
      state.sda_level        <= 1'b1;
      state.sda_drive        <= 1'b1;
    end else if (step) begin
      state <= state_next;
    end
  end

  // header byte for a start command, R/W from the command kind
  always_comb begin
    if (address < i2cms_pkg::ADDR7_LIMIT) begin
      header = {address[6:0], kind == i2cms_pkg::KIND_START_READ};
    end else begin
      header = {i2cms_pkg::HDR10_PREFIX, address[9:8], kind == i2cms_pkg::KIND_START_READ};
    end
  end

  always_comb begin
    state_next = state;
    do_enter   = 1'b0;
    target     = i2cms_pkg::PH_IDLE;
    accepted   = 1'b0;
    done_now   = 1'b0;
    read_now   = 1'b0;
    wbit       = 1'b1;

    if (kind == i2cms_pkg::KIND_TICK) begin
      if (state.phase != i2cms_pkg::PH_IDLE) begin
        state_next.delay_count = state.delay_count + 16'd1;
        if (state_next.delay_count >= delay) begin
          unique case (state.phase)
            i2cms_pkg::PH_RESTART: begin
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_START_A;
            end
            i2cms_pkg::PH_START_A: begin
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_START_B;
            end
            i2cms_pkg::PH_START_B: begin
              state_next.bus_started = 1'b1;
              state_next.ack_flag    = 1'b1;
              state_next.bit_index   = '0;
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_WB_SETUP;
            end
            i2cms_pkg::PH_WB_SETUP: begin
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_WB_HIGH;
            end
            i2cms_pkg::PH_WB_HIGH: begin
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_WB_LOW;
            end
            i2cms_pkg::PH_WB_LOW: begin
              if (state.active_command == i2cms_pkg::KIND_READ_BYTE) begin
                // master ACK/NACK bit just went out
                if (state.bytes_left > 16'd1) begin
                  state_next.bytes_left = state.bytes_left - 16'd1;
                  done_now = 1'b1;
                end else begin
                  state_next.bytes_left = '0;
                  do_enter = 1'b1;
                  target   = i2cms_pkg::PH_STOP_A;
                end
              end else begin
                state_next.bit_index = state.bit_index + 4'd1;
                do_enter = 1'b1;
                target   = (state_next.bit_index < i2cms_pkg::BITS_PER_BYTE) ?
                           i2cms_pkg::PH_WB_SETUP : i2cms_pkg::PH_RB_HIGH;
              end
            end
            i2cms_pkg::PH_RB_HIGH: begin
              if (state.active_command == i2cms_pkg::KIND_READ_BYTE) begin
                state_next.shift_byte = {state.shift_byte[6:0], sda_in};
              end else if (sda_in) begin
                state_next.ack_flag = 1'b0;
              end
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_RB_LOW;
            end
            i2cms_pkg::PH_RB_LOW: begin
              if (state.active_command == i2cms_pkg::KIND_READ_BYTE) begin
                state_next.bit_index = state.bit_index + 4'd1;
                do_enter = 1'b1;
                target   = (state_next.bit_index < i2cms_pkg::BITS_PER_BYTE) ?
                           i2cms_pkg::PH_RB_HIGH : i2cms_pkg::PH_WB_SETUP;
              end else if (state.pending_flag) begin
                // second header byte of a 10-bit address
                state_next.shift_byte   = state.pending_low_byte;
                state_next.pending_flag = 1'b0;
                state_next.bit_index    = '0;
                do_enter = 1'b1;
                target   = i2cms_pkg::PH_WB_SETUP;
              end else begin
                if (state.active_command == i2cms_pkg::KIND_START_READ && !state.ack_flag) begin
                  state_next.bytes_left = '0;
                end
                done_now = 1'b1;
              end
            end
            i2cms_pkg::PH_STOP_A: begin
              do_enter = 1'b1;
              target   = i2cms_pkg::PH_STOP_B;
            end
            i2cms_pkg::PH_STOP_B: begin
              state_next.bus_started = 1'b0;
              done_now = 1'b1;
            end
            default: begin
              state_next.phase = i2cms_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end else if (kind <= i2cms_pkg::KIND_READ_BYTE && state.phase == i2cms_pkg::PH_IDLE) begin
      accepted = 1'b1;
      state_next.active_command = kind;
      state_next.bit_index      = '0;
      do_enter = 1'b1;
      priority if (kind == i2cms_pkg::KIND_START_WRITE || kind == i2cms_pkg::KIND_START_READ) begin
        state_next.shift_byte = header;
        if (address < i2cms_pkg::ADDR7_LIMIT) begin
          state_next.pending_flag = 1'b0;
        end else begin
          state_next.pending_low_byte = address[7:0];
          state_next.pending_flag     = 1'b1;
        end
        if (kind == i2cms_pkg::KIND_START_READ) begin
          state_next.bytes_left = (count > CountMax) ? CountMax : count;
        end
        target = state.bus_started ? i2cms_pkg::PH_RESTART : i2cms_pkg::PH_START_A;
      end else if (kind == i2cms_pkg::KIND_WRITE_BYTE) begin
        state_next.shift_byte   = data;
        state_next.pending_flag = 1'b0;
        target = i2cms_pkg::PH_WB_SETUP;
      end else if (kind == i2cms_pkg::KIND_END_WRITE) begin
        target = i2cms_pkg::PH_STOP_A;
      end else begin
        state_next.shift_byte = '0;
        target = i2cms_pkg::PH_RB_HIGH;
      end
    end

    if (done_now) begin
      state_next.phase       = i2cms_pkg::PH_IDLE;
      state_next.delay_count = '0;
      read_now = (state_next.active_command == i2cms_pkg::KIND_READ_BYTE);
    end

    // bit driven in a write-bit phase: data MSB first, or ACK/NACK on a read
    if (state_next.active_command == i2cms_pkg::KIND_READ_BYTE) begin
      wbit = !(state_next.bytes_left > 16'd1);
    end else begin
      wbit = state_next.shift_byte[3'd7 - state_next.bit_index[2:0]];
    end

    if (do_enter) begin
      state_next.phase       = target;
      state_next.delay_count = '0;
      unique case (target)
        i2cms_pkg::PH_RESTART: begin
          state_next.sda_drive = 1'b1;
          state_next.sda_level = 1'b1;
          state_next.scl_level = 1'b1;
        end
        i2cms_pkg::PH_START_A: begin
          state_next.sda_drive = 1'b1;
          state_next.sda_level = 1'b0;
        end
        i2cms_pkg::PH_START_B: state_next.scl_level = 1'b0;
        i2cms_pkg::PH_WB_SETUP: begin
          state_next.sda_drive = 1'b1;
          state_next.sda_level = wbit;
        end
        i2cms_pkg::PH_WB_HIGH: state_next.scl_level = 1'b1;
        i2cms_pkg::PH_WB_LOW:  state_next.scl_level = 1'b0;
        i2cms_pkg::PH_RB_HIGH: begin
          state_next.sda_drive = 1'b0;
          state_next.sda_level = 1'b1;
          state_next.scl_level = 1'b1;
        end
        i2cms_pkg::PH_RB_LOW: state_next.scl_level = 1'b0;
        i2cms_pkg::PH_STOP_A: begin
          state_next.sda_drive = 1'b1;
          state_next.sda_level = 1'b0;
          state_next.scl_level = 1'b1;
        end
        i2cms_pkg::PH_STOP_B: state_next.sda_level = 1'b1;
        default: state_next.phase = i2cms_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    result.scl_out    = state_next.scl_level;
    result.sda_out    = state_next.sda_level;
    result.sda_enable = state_next.sda_drive;
    result.busy_res   = (state_next.phase != i2cms_pkg::PH_IDLE);
    result.accepted   = accepted;
    result.done_res   = done_now;
    result.acked      = state_next.ack_flag;
    result.read_valid = read_now;
    result.read_data  = read_now ? state_next.shift_byte : 8'd0;
    result.remaining  = state_next.bytes_left;
  end

endmodule

FILE: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: top level with config register and output item register.
// Depends on i2cms_pkg, i2cms_seq and i2c_master_bit_sequencer_defines.svh.
//
// Usage:
//  - Input channel (in_valid/in_stall): one item per command or tick. kind 0 is
//    a tick that advances the current bus phase; kinds 1..5 are commands, taken
//    only while idle (accepted=0 in the result otherwise). kinds 6, 7 do nothing.
//  - Output channel (out_valid/out_stall): exactly one result item per input
//    item, in order: pin levels after the item, busy/done/acked, read byte.
//  - cfg_we/cfg_wdata write delay_ticks (ticks per bus phase, 0 acts as 1);
//    write it only while the block is idle.
//  - The result item is registered and appears in the cycle after the input item is taken.
//  - Throughput: one item per clock when not stalled; the sequencer step is
//    one pass of next-state logic between the phase and output registers.
//  - Stall: while out_stall holds a waiting result, in_stall is raised and the
//    result is held; as soon as the result is taken a new item can enter the
//    same cycle.
//  - Reset (rst, synchronous): sequencer state idle with SCL and SDA high and
//    SDA driven, ack flag set, delay_ticks = 1, no result pending.
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer #(
  parameter int COUNT_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [9:0]  address,
  input  logic [7:0]  data,
  input  logic [15:0] count,
  input  logic        sda_in,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        sda_enable,
  output logic        busy_res,
  output logic        accepted,
  output logic        done_res,
  output logic        acked,
  output logic        read_valid,
  output logic [7:0]  read_data,
  output logic [15:0] remaining
);

  logic [15:0]        delay_ticks;
  logic [15:0]        delay_eff;
  logic               in_take;
  i2cms_pkg::result_t step_result;
  i2cms_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= 16'd1;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  // a zero delay behaves as one tick per phase
  assign delay_eff = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;

  // the output register frees up in the same cycle its item is taken
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  i2cms_seq #(
    .COUNT_MAX (COUNT_MAX)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (in_take),
    .kind    (kind),
    .address (address),
    .data    (data),
    .count   (count),
    .sda_in  (sda_in),
    .delay   (delay_eff),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      result <= step_result;
    end
  end

  assign scl_out    = result.scl_out;
  assign sda_out    = result.sda_out;
  assign sda_enable = result.sda_enable;
  assign busy_res   = result.busy_res;
  assign accepted   = result.accepted;
  assign done_res   = result.done_res;
  assign acked      = result.acked;
  assign read_valid = result.read_valid;
  assign read_data  = result.read_data;
  assign remaining  = result.remaining;

  `I2CMS_ASSERT_NEXT(a_take_gives_result, clk, rst, in_valid && !in_stall, out_valid)
  `I2CMS_ASSERT_IMP(a_read_implies_done, clk, rst, out_valid && read_valid, done_res && !busy_res)
  `I2CMS_ASSERT_IMP(a_accept_not_done, clk, rst, out_valid && accepted, busy_res && !done_res)
  `I2CMS_ASSERT_IMP(a_read_data_zero, clk, rst, out_valid && !read_valid, read_data == 8'd0)

endmodule
